>>> rtl/core/insertion_sorter_defines.svh
// Assertion macros shared by the insertion sorter checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define ISRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("insertion_sorter assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ISRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("insertion_sorter assertion failed");

`endif

>>> rtl/core/isrt_pkg.sv
// Shared types and constants for the insertion sorter.
// No dependencies; imported by every module of the block.
package isrt_pkg;

  localparam int VALUE_WIDTH = 32;

  typedef logic signed [VALUE_WIDTH-1:0] isrt_val_t;

  typedef struct packed {
    isrt_val_t value;
    logic      last;
  } isrt_in_t;

  typedef struct packed {
    isrt_val_t sorted_value;
    logic      final_res;
    logic      overflow;
  } isrt_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift;
  } isrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_one;
  } isrt_sts_t;

endpackage

>>> rtl/core/isrt_dp.sv
// Datapath of the insertion sorter: ordered register row, element count, drop flag.
// Depends on isrt_pkg.
module isrt_dp import isrt_pkg::*; #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  isrt_cmd_t cmd,
  input  isrt_val_t in_value,
  output isrt_sts_t sts,
  output isrt_out_t out_item
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  isrt_val_t       row_r   [MAX_ELEMENTS];
  isrt_val_t       row_nxt [MAX_ELEMENTS];
  logic [CW-1:0]   count_r, count_nxt;
  logic            drop_r, drop_nxt;
  logic            full;
  logic            last_one;
  logic [MAX_ELEMENTS-1:0] goes_below;

  assign full     = (count_r == CW'(MAX_ELEMENTS));
  assign last_one = (count_r == CW'(1));

  // An entry at or above the insertion point sees a set bit: either a stored
  // entry greater than the new value, or a slot past the end of the list.
  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      goes_below[i] = (CW'(i) < count_r) ? (row_r[i] > in_value) : 1'b1;
    end
  end

  always_comb begin
    row_nxt   = row_r;
    count_nxt = count_r;
    drop_nxt  = drop_r;
    if (cmd.load) begin
      if (full) begin
        drop_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
          if (i > 0 && goes_below[(i > 0) ? i - 1 : 0]) begin
            row_nxt[i] = row_r[(i > 0) ? i - 1 : 0];
          end else if (goes_below[i]) begin
            row_nxt[i] = in_value;
          end
        end
      end
    end else if (cmd.shift) begin
      // Emission shifts the row down so the next result is always in entry zero.
      count_nxt = count_r - CW'(1);
      for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
        row_nxt[i] = row_r[i + 1];
      end
      if (last_one) begin
        drop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    if (!rst_n) begin
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
  end

  assign sts.last_one          = last_one;
  assign out_item.sorted_value = row_r[0];
  assign out_item.final_res    = last_one;
  assign out_item.overflow     = drop_r;

endmodule

>>> rtl/core/isrt_ctrl.sv
// Controller of the insertion sorter: load and emit phases, handshake registers.
// Depends on isrt_pkg.
module isrt_ctrl import isrt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  isrt_sts_t sts,
  output isrt_cmd_t cmd
);

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_accept, out_accept;

  assign in_accept  = in_valid && !in_stall_r;
  assign out_accept = out_valid_r && !out_stall;

  always_comb begin
    state_nxt     = state_r;
    in_stall_nxt  = in_stall_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      ST_LOAD: begin
        if (in_accept && in_last) begin
          state_nxt     = ST_EMIT;
          in_stall_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_accept && sts.last_one) begin
          state_nxt     = ST_LOAD;
          in_stall_nxt  = 1'b0;
          out_valid_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt     = ST_LOAD;
        in_stall_nxt  = 1'b0;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;
  assign cmd.load  = in_accept;
  assign cmd.shift = out_accept;

endmodule

>>> rtl/core/insertion_sorter.sv
// Insertion sorter. Loading takes one value per cycle while in_stall is low: each
// value is placed into a register row by a parallel compare-and-shift in the cycle
// it is accepted. The first result is valid the cycle after the last value is accepted;
// results then leave at one per cycle while out_stall is low, as the row shifts down,
// and the input stalls until the final one. N values yield min(N, MAX_ELEMENTS) results.
// Synchronous active-low reset empties the list at once; no clearing pass is needed.
module insertion_sorter import isrt_pkg::*; #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  isrt_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output isrt_out_t out_data
);

  isrt_cmd_t cmd;
  isrt_sts_t sts;

  isrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  isrt_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_value (in_data.value),
    .sts      (sts),
    .out_item (out_data)
  );

endmodule

>>> rtl/core/isrt_checker.sv
// Port-level checker for the insertion sorter, bound to the top level.
// Depends on isrt_pkg and insertion_sorter_defines.svh.
`include "insertion_sorter_defines.svh"

module isrt_checker import isrt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input isrt_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input isrt_out_t out_data
);

  // A stalled result transaction holds its payload.
  `ISRT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // No value is taken while results of the previous set are pending.
  `ISRT_ASSERT_IMP(a_no_load_in_emit, clk, rst_n, out_valid, in_stall)

  // Closing a set always produces at least one result.
  `ISRT_ASSERT_NXT(a_last_emits, clk, rst_n, in_valid && !in_stall && in_data.last, out_valid)

  // Results stop right after the final one is taken.
  `ISRT_ASSERT_NXT(a_final_ends, clk, rst_n, out_valid && !out_stall && out_data.final_res,
                   !out_valid && !in_stall)

  // Results of a set keep coming until the final one.
  `ISRT_ASSERT_NXT(a_emit_continues, clk, rst_n, out_valid && !out_stall && !out_data.final_res,
                   out_valid)

endmodule

bind insertion_sorter isrt_checker u_isrt_checker (.*);
